### rtl/core/mbrc_pkg.sv
// shared types, constants and crc function for the modbus rtu request checker
package mbrc_pkg;

	localparam int unsigned HDR_LEN         = 6;
	localparam int unsigned MIN_FRAME_LEN   = 4;
	localparam int unsigned INPUT_REG_COUNT = 16;
	localparam int unsigned COIL_LIMIT      = 4;
	localparam int unsigned NUM_COILS       = 4;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;

	// byte counter saturates once the header is full
	typedef logic [2:0] pos_t;
	localparam pos_t POS_SAT = pos_t'(HDR_LEN);

	typedef logic [2:0] status_t;
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_WRONG_ADDR  = 3'd1;
	localparam status_t ST_BAD_CRC     = 3'd2;
	localparam status_t ST_ILLEGAL_FN  = 3'd3;
	localparam status_t ST_ILLEGAL_ADR = 3'd4;
	localparam status_t ST_ILLEGAL_VAL = 3'd5;

	localparam logic [7:0] FC_READ_COILS     = 8'd1;
	localparam logic [7:0] FC_READ_INPUT_REG = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL     = 8'd5;

	typedef logic [HDR_LEN-1:0][7:0] hdr_t;
	typedef logic [NUM_COILS-1:0]    coil_t;

	typedef struct packed {
		status_t status;
		coil_t   coils;
	} eval_t;

	// reflected crc-16, one byte folded in per call
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/mbrc_if.sv
// valid/ready channel interfaces for request bytes and check results
interface mbrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source (output valid, output rx_byte, output last_byte, input ready);
	modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface mbrc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  function_code;
	logic [15:0] start_address;
	logic [15:0] quantity_or_value;
	logic [3:0]  coil_outputs;

	modport source (output valid, output status, output function_code, output start_address,
		output quantity_or_value, output coil_outputs, input ready);
	modport sink   (input valid, input status, input function_code, input start_address,
		input quantity_or_value, input coil_outputs, output ready);
endinterface

### rtl/core/mbrc_eval.sv
// end-of-frame checks: address, crc, function and range, plus coil update
module mbrc_eval import mbrc_pkg::*; #(
	parameter int unsigned REG_COUNT = INPUT_REG_COUNT,
	parameter int unsigned COIL_MAX  = COIL_LIMIT
) (
	input  logic [7:0]  slave_address,
	input  hdr_t        hdr,
	input  logic [15:0] crc_residue,
	input  pos_t        frame_len,
	input  coil_t       coils_cur,
	output eval_t       result
);

	logic [15:0] addr;
	logic [15:0] qty;
	logic [16:0] addr_end;
	coil_t       coil_mask;

	assign addr      = {hdr[2], hdr[3]};
	assign qty       = {hdr[4], hdr[5]};
	assign addr_end  = {1'b0, addr} + {1'b0, qty};
	assign coil_mask = coil_t'(1) << addr[1:0];

	always_comb begin
		result.coils = coils_cur;
		priority if (hdr[0] != slave_address) begin
			result.status = ST_WRONG_ADDR;
		end else if (frame_len < pos_t'(MIN_FRAME_LEN) || crc_residue != 16'h0000) begin
			result.status = ST_BAD_CRC;
		end else if (hdr[1] == FC_READ_COILS) begin
			result.status = ST_OK;
		end else if (hdr[1] == FC_READ_INPUT_REG) begin
			priority if (qty > 16'(REG_COUNT)) begin
				result.status = ST_ILLEGAL_VAL;
			end else if (addr_end > 17'(REG_COUNT)) begin
				result.status = ST_ILLEGAL_ADR;
			end else begin
				result.status = ST_OK;
			end
		end else if (hdr[1] == FC_WRITE_COIL) begin
			if (addr >= 16'(COIL_MAX)) begin
				result.status = ST_ILLEGAL_ADR;
			end else begin
				result.status = ST_OK;
				result.coils  = (qty != 16'h0000) ? (coils_cur | coil_mask)
				                                  : (coils_cur & ~coil_mask);
			end
		end else begin
			result.status = ST_ILLEGAL_FN;
		end
	end

endmodule

### rtl/core/modbus_rtu_request_checker_core.sv
// top level of the modbus rtu request checker
//
// channels:
//   req carries one frame byte per item in wire order, last_byte marks the
//   final byte (crc high byte). rsp carries one item per frame, issued on
//   the final byte: status, function code, start address, quantity or
//   value and the four coil outputs. cfg_wr_en / cfg_wr_data set the own
//   station address; write it only while no frame is in flight.
// pipeline and throughput:
//   a byte is registered on acceptance in the input register; the crc
//   update and, on the last byte, all checks run from there into the
//   output register, which drives rsp. while no last byte waits, one byte
//   per cycle is sustained; the byte-wide unrolled crc step sets that path.
// reset:
//   crc 0xffff, byte count and header zero, coils off, station address 1.
// stall:
//   a result waits in the output register while rsp.ready is low. other
//   bytes still flow; a last byte waits in the input register, with
//   req.ready low, until the output register frees.
module modbus_rtu_request_checker_core import mbrc_pkg::*; #(
	parameter int unsigned REG_COUNT = INPUT_REG_COUNT,
	parameter int unsigned COIL_MAX  = COIL_LIMIT
) (
	input  logic         clk,
	input  logic         arst_n,
	mbrc_in_if.sink      req,
	mbrc_out_if.source   rsp,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data
);

	logic [7:0]  slave_addr_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// frame state
	logic [15:0] crc_q;
	pos_t        pos_q;
	hdr_t        hdr_q;
	coil_t       coil_q;

	logic [15:0] crc_next;
	pos_t        pos_next;
	hdr_t        hdr_now;
	eval_t       eval;

	logic        out_free;
	logic        go_s1;

	// output register
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  func_q;
	logic [15:0] start_q;
	logic [15:0] qty_q;
	coil_t       coils_out_q;

	// a last byte needs room in the output register, other bytes never wait
	assign out_free  = !out_valid_q || rsp.ready;
	assign go_s1     = valid_s1 && (!last_s1 || out_free);
	assign req.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
		end else if (cfg_wr_en) begin
			slave_addr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			byte_s1 <= req.rx_byte;
			last_s1 <= req.last_byte;
		end
	end

	// crc and byte count after the byte in the input register
	assign crc_next = crc16_byte(crc_q, byte_s1);
	assign pos_next = (pos_q == POS_SAT) ? pos_q : pos_q + pos_t'(1);

	// header as seen with the current byte folded in
	always_comb begin
		hdr_now = hdr_q;
		for (int k = 0; k < HDR_LEN; k++) begin
			if (pos_q == pos_t'(k)) begin
				hdr_now[k] = byte_s1;
			end
		end
	end

	mbrc_eval #(
		.REG_COUNT (REG_COUNT),
		.COIL_MAX  (COIL_MAX)
	) u_eval (
		.slave_address (slave_addr_q),
		.hdr           (hdr_now),
		.crc_residue   (crc_next),
		.frame_len     (pos_next),
		.coils_cur     (coil_q),
		.result        (eval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			pos_q  <= '0;
			coil_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				// frame done: restart crc and count, commit coils
				crc_q  <= CRC_INIT;
				pos_q  <= '0;
				coil_q <= eval.coils;
			end else begin
				crc_q <= crc_next;
				pos_q <= pos_next;
			end
		end
	end

	// header capture, bytes past the sixth are dropped; cleared at frame end
	// so bytes a short frame never reaches read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				hdr_q <= '0;
			end else if (pos_q < POS_SAT) begin
				hdr_q <= hdr_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			status_q    <= eval.status;
			func_q      <= hdr_now[1];
			start_q     <= {hdr_now[2], hdr_now[3]};
			qty_q       <= {hdr_now[4], hdr_now[5]};
			coils_out_q <= eval.coils;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.status            = status_q;
	assign rsp.function_code     = func_q;
	assign rsp.start_address     = start_q;
	assign rsp.quantity_or_value = qty_q;
	assign rsp.coil_outputs      = coils_out_q;

endmodule

### dv/mbrc_tb_pkg.sv
// testbench byte queue type and crc fold for the modbus rtu request checker
`timescale 1ns / 100ps
package mbrc_tb_pkg;
	import mbrc_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// bit-serial form: feedback is crc lsb xor data bit, lsb first
	function automatic logic [15:0] modbus_crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		logic        fb;
		acc = crc;
		for (int i = 0; i < 8; i++) begin
			fb  = acc[0] ^ b[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

endpackage

### dv/mbrc_checker.sv
// request predictor and result checker for the modbus rtu request checker
`timescale 1ns / 100ps
module mbrc_checker import mbrc_pkg::*, mbrc_tb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mbrc_in_if         req,
	mbrc_out_if        rsp,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output int         fail_count,
	output int         pending,
	output int         results_checked,
	output logic [7:0] status_seen
);

	typedef struct packed {
		status_t     status;
		logic [7:0]  fc;
		logic [15:0] start;
		logic [15:0] qv;
		coil_t       coils;
	} frame_verdict_t;

	frame_verdict_t verdict_q[$];

	logic [15:0] frame_crc;
	int unsigned frame_len;
	logic [7:0]  hdr [HDR_LEN];
	coil_t       coil_state;
	logic [7:0]  own_station;

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t v;
		frame_verdict_t got;
		logic [16:0]    reach;
		logic           bad;
		if (!arst_n) begin
			verdict_q.delete();
			frame_crc       = CRC_INIT;
			frame_len       = 0;
			for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
			coil_state      = '0;
			own_station     = SLAVE_ADDR_RESET;
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
			status_seen     = '0;
		end else begin
			if (cfg_wr_en) begin
				own_station = cfg_wr_data;
			end

			// compare an outgoing result with the oldest verdict
			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.fc     = rsp.function_code;
				got.start  = rsp.start_address;
				got.qv     = rsp.quantity_or_value;
				got.coils  = rsp.coil_outputs;
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result with no request pending: status %0d fc %h",
							$time, got.status, got.fc);
					end
				end else begin
					v   = verdict_q.pop_front();
					// header bytes that the frame never reached read as zero
					bad = (got.status != v.status) || (got.coils != v.coils)
						|| (got.fc != v.fc) || (got.start != v.start)
						|| (got.qv != v.qv);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch exp st %0d fc %h sa %h qv %h coils %b",
								$time, v.status, v.fc, v.start, v.qv, v.coils);
							$display("%0t:          got st %0d fc %h sa %h qv %h coils %b",
								$time, got.status, got.fc, got.start, got.qv, got.coils);
						end
					end
					status_seen[v.status] = 1'b1;
					results_checked++;
				end
			end

			// fold an accepted byte into the frame
			if (req.valid && req.ready) begin
				frame_crc = modbus_crc_fold(frame_crc, req.rx_byte);
				if (frame_len < HDR_LEN) begin
					hdr[frame_len] = req.rx_byte;
				end
				if (frame_len < 255) frame_len++;
				if (req.last_byte) begin
					v.fc    = hdr[1];
					v.start = {hdr[2], hdr[3]};
					v.qv    = {hdr[4], hdr[5]};
					reach   = {1'b0, v.start} + {1'b0, v.qv};
					if (hdr[0] != own_station) begin
						v.status = ST_WRONG_ADDR;
					end else if (frame_len < MIN_FRAME_LEN || frame_crc != 16'h0000) begin
						v.status = ST_BAD_CRC;
					end else if (v.fc == FC_READ_COILS) begin
						v.status = ST_OK;
					end else if (v.fc == FC_READ_INPUT_REG) begin
						if (v.qv > INPUT_REG_COUNT) begin
							v.status = ST_ILLEGAL_VAL;
						end else if (reach > INPUT_REG_COUNT) begin
							v.status = ST_ILLEGAL_ADR;
						end else begin
							v.status = ST_OK;
						end
					end else if (v.fc == FC_WRITE_COIL) begin
						if (v.start >= COIL_LIMIT) begin
							v.status = ST_ILLEGAL_ADR;
						end else begin
							coil_state[v.start[1:0]] = (v.qv != 16'h0000);
							v.status = ST_OK;
						end
					end else begin
						v.status = ST_ILLEGAL_FN;
					end
					v.coils = coil_state;
					verdict_q.push_back(v);
					frame_crc = CRC_INIT;
					frame_len = 0;
					for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

### dv/tb_modbus_rtu_request_checker_core.sv
// testbench top: stimulus, receiver stalls and verdict for the request checker
`timescale 1ns / 100ps
module tb_modbus_rtu_request_checker_core;
	import mbrc_pkg::*;
	import mbrc_tb_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       rsp_take = 1'b0;

	// idle chances in percent per cycle, changed only between phases
	int         req_idle_pct;
	int         rsp_idle_pct;
	int         bytes_sent;
	logic [7:0] station;

	int         fail_count;
	int         pending;
	int         results_checked;
	logic [7:0] status_seen;

	mbrc_in_if  req_if ();
	mbrc_out_if rsp_if ();

	assign rsp_if.ready = rsp_take;

	modbus_rtu_request_checker_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	mbrc_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_if),
		.rsp             (rsp_if),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.status_seen     (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: drop ready at random, held low through reset
	always @(posedge clk) begin
		rsp_take <= arst_n && ($urandom_range(99) >= rsp_idle_pct);
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// one byte item; sender may idle at random first, acceptance seen via ready mid-cycle
	task automatic put_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < req_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.rx_byte   <= b;
		req_if.last_byte <= last;
		do @(negedge clk); while (!req_if.ready);
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input byte_q_t q);
		foreach (q[i]) put_byte(q[i], i == q.size() - 1);
	endtask

	// append the crc low byte first; a corrupt frame gets one crc bit flipped
	function automatic byte_q_t with_crc(input byte_q_t body, input bit corrupt);
		logic [15:0] c;
		byte_q_t     framed;
		c      = CRC_INIT;
		framed = body;
		foreach (body[i]) c = modbus_crc_fold(c, body[i]);
		if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
		framed.push_back(c[7:0]);
		framed.push_back(c[15:8]);
		return framed;
	endfunction

	// well-formed request: station, function, address, quantity, optional trailing bytes
	task automatic send_request(input logic [7:0] st, input logic [7:0] fc,
			input logic [15:0] sa, input logic [15:0] qv, input int n_extra, input bit corrupt);
		byte_q_t body;
		body = '{st, fc, sa[15:8], sa[7:0], qv[15:8], qv[7:0]};
		repeat (n_extra) body.push_back(8'($urandom));
		send_bytes(with_crc(body, corrupt));
	endtask

	// stop sending until every result is back, then let the pipeline settle
	task automatic drain_requests();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_station(input logic [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		station      = v;
	endtask

	// mostly well-formed requests with random content, then short frames and noise
	task automatic send_random_request();
		byte_q_t     body;
		int unsigned pick;
		int unsigned n;
		logic [7:0]  st;
		logic [7:0]  fc;
		logic [15:0] sa;
		logic [15:0] qv;
		pick = $urandom_range(99);
		st   = ($urandom_range(99) < 85) ? station : 8'($urandom);
		if (pick < 78) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					fc = FC_READ_INPUT_REG;
				end
				3, 4, 5: begin
					fc = FC_WRITE_COIL;
				end
				6, 7: begin
					fc = FC_READ_COILS;
				end
				default: begin
					fc = 8'($urandom);
				end
			endcase
			if (fc == FC_WRITE_COIL) begin
				// coil index mostly near the limit, value zero, the standard on, or anything
				sa = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(5));
				case ($urandom_range(2))
					0: begin
						qv = 16'h0000;
					end
					1: begin
						qv = 16'hFF00;
					end
					default: begin
						qv = 16'($urandom);
					end
				endcase
			end else begin
				// register window mostly around the limit, sometimes the full range
				sa = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(20));
				qv = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(20));
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : 0;
			send_request(st, fc, sa, qv, n, $urandom_range(99) < 12);
		end else if (pick < 92) begin
			// short frame; header bytes it never reaches read as zero
			n = $urandom_range(5, 1);
			body.push_back(($urandom_range(99) < 70) ? station : 8'($urandom));
			if (n >= 4) begin
				case ($urandom_range(2))
					0: begin
						fc = FC_READ_INPUT_REG;
					end
					1: begin
						fc = FC_WRITE_COIL;
					end
					default: begin
						fc = 8'($urandom);
					end
				endcase
				body.push_back(fc);
				if (n == 5) body.push_back(8'($urandom));
				send_bytes(with_crc(body, $urandom_range(1) == 0));
			end else begin
				repeat (n - 1) body.push_back(8'($urandom));
				send_bytes(body);
			end
		end else begin
			// line noise long enough to fill the header
			n = $urandom_range(12, 6);
			repeat (n) body.push_back(8'($urandom));
			send_bytes(body);
		end
	endtask

	task automatic random_phase(input logic [7:0] st, input int snd_pct, input int rcv_pct);
		int start_bytes;
		drain_requests();
		write_station(st);
		req_idle_pct = snd_pct;
		rsp_idle_pct = rcv_pct;
		start_bytes  = bytes_sent;
		while (bytes_sent - start_bytes < 220) send_random_request();
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = 8'h00;
		req_if.valid     = 1'b0;
		req_if.rx_byte   = 8'h00;
		req_if.last_byte = 1'b0;
		req_idle_pct     = 16;
		rsp_idle_pct     = 56;
		bytes_sent       = 0;
		station          = SLAVE_ADDR_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset station address; first frame fills the header
		send_request(station, FC_READ_COILS, 16'h0000, 16'h0001, 0, 1'b0);
		send_request(station, FC_READ_INPUT_REG, 16'h0000, 16'd16, 0, 1'b0);
		send_request(station, FC_READ_INPUT_REG, 16'h0000, 16'd17, 0, 1'b0);
		send_request(station, FC_READ_INPUT_REG, 16'h0001, 16'd16, 0, 1'b0);
		// address plus count wraps 16 bits but must still be out of range
		send_request(station, FC_READ_INPUT_REG, 16'hFFFF, 16'd10, 0, 1'b0);
		send_request(station, FC_READ_INPUT_REG, 16'h0000, 16'hFFFF, 0, 1'b0);
		send_request(station, FC_WRITE_COIL, 16'h0003, 16'hFF00, 0, 1'b0);
		send_request(station, FC_WRITE_COIL, 16'h0000, 16'hFFFF, 0, 1'b0);
		send_request(station, FC_WRITE_COIL, 16'h0003, 16'h0000, 0, 1'b0);
		send_request(station, FC_WRITE_COIL, 16'h0004, 16'hFF00, 0, 1'b0);
		send_request(station, FC_WRITE_COIL, 16'hFFFF, 16'hFFFF, 0, 1'b0);
		send_request(station, 8'h03, 16'h0000, 16'h0001, 0, 1'b0);
		send_request(station, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 1'b0);
		send_request(station, 8'h00, 16'h0000, 16'h0000, 0, 1'b0);
		send_request(8'hF0, FC_READ_COILS, 16'h0000, 16'h0001, 0, 1'b0);
		send_request(station, FC_READ_COILS, 16'h0000, 16'h0001, 0, 1'b1);
		// long frame: trailing bytes past the header still go into the crc
		send_request(station, FC_READ_COILS, 16'h00AA, 16'h0055, 4, 1'b0);
		// short frames: under four bytes a crc fault when the station matches
		send_bytes('{station, FC_READ_COILS, 8'h00});
		send_bytes('{station});
		send_bytes('{8'hFF});
		// four and five byte frames with a valid crc
		send_bytes(with_crc('{station, FC_READ_COILS}, 1'b0));
		send_bytes(with_crc('{station, 8'h07, 8'hAA}, 1'b0));

		// random phases: station extremes and one midrange, idling swapped, then none
		random_phase(8'h00, 16, 56);
		random_phase(8'hFF, 56, 16);
		random_phase(8'($urandom_range(254, 1)), 0, 0);

		drain_requests();
		repeat (8) @(posedge clk);
		$display("covered %0d request bytes, %0d results checked, stations 01/00/FF/%h",
			bytes_sent, results_checked, station);
		$display("status codes observed (bit per code): %b", status_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
